// ----- hw/rtl/rgbpq_pkg.sv -----
// shared types and constants of the rgb565 palette quantizer
package rgbpq_pkg;

	localparam int unsigned PalCount   = 7;
	localparam int unsigned ColorW     = 24;
	localparam int unsigned ChanW      = 8;
	localparam int unsigned SqW        = 2 * ChanW;
	localparam int unsigned DistW      = 19;
	localparam int unsigned CoordW     = 11;
	localparam int unsigned PixW       = 16;
	localparam int unsigned PosW       = 2 * CoordW + 1;
	localparam int unsigned AddrW      = 18;
	localparam int unsigned IdxW       = 3;
	localparam int unsigned InDataW    = 40;
	localparam int unsigned OutDataW   = 24;
	localparam int unsigned ApbAddrW   = 5;
	localparam int unsigned ApbDataW   = 32;

	typedef logic [ColorW-1:0] color_t;
	typedef logic [IdxW-1:0]   idx_t;
	typedef logic [DistW-1:0]  dist_t;

	// register map, one word per palette entry
	typedef enum logic [IdxW-1:0] {
		REG_BLACK  = 3'd0,
		REG_WHITE  = 3'd1,
		REG_GREEN  = 3'd2,
		REG_BLUE   = 3'd3,
		REG_RED    = 3'd4,
		REG_YELLOW = 3'd5,
		REG_ORANGE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [ChanW-1:0] r;
		logic [ChanW-1:0] g;
		logic [ChanW-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic [SqW-1:0] r;
		logic [SqW-1:0] g;
		logic [SqW-1:0] b;
	} sq_t;

	localparam color_t PalReset [PalCount] = '{
		24'h000000, 24'hFFFFFF, 24'h438A1C, 24'h6440FF,
		24'hE41C1C, 24'hC7C70A, 24'hF8BE00
	};

	function automatic logic [SqW-1:0] sq_diff(input logic [ChanW-1:0] a,
			input logic [ChanW-1:0] b);
		logic [ChanW-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return SqW'(d) * SqW'(d);
	endfunction

endpackage

// ----- hw/rtl/rgb565_palette_quantize_pack.sv -----
// top level: rgb565 pixel to nearest palette nibble write, three-stage pipeline
//
// Takes one RGB565 pixel with its screen coordinates per transfer and returns one frame-buffer
// nibble write per pixel, in order. The pipeline accepts a pixel every clock unless all stages
// are full and the output is stalled. Each pixel passes the stage registers in order: stage one
// registers the pixel, stage two holds the 21 channel squared differences against the seven
// palette entries and the linear position y*DISPLAY_WIDTH+x, stage three holds the index of the
// weighted distance minimum and is the output register. Each stage fills independently, so input
// keeps flowing into empty stages while a result waits. Pixels off the display come out with
// write_enable low and all other fields zero. The palette is seven 24-bit APB registers at byte
// addresses 0x00..0x18 and must only be written while no pixel is in flight.
module rgb565_palette_quantize_pack #(
	parameter int DISPLAY_WIDTH  = 800,
	parameter int DISPLAY_HEIGHT = 480
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pixel_x [10:0], pixel_y [21:11], pixel_color [37:22], zero [39:38]
	input  logic [rgbpq_pkg::InDataW-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// write_enable [0], byte_address [18:1], high_nibble [19], color_index [22:20], zero [23]
	output logic [rgbpq_pkg::OutDataW-1:0]   m_axis_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rgbpq_pkg::ApbAddrW-1:0]   paddr,
	input  logic [rgbpq_pkg::ApbDataW-1:0]   pwdata,
	output logic [rgbpq_pkg::ApbDataW-1:0]   prdata,
	output logic                             pready
);
	import rgbpq_pkg::*;

	localparam logic [CoordW:0]   WidthC  = (CoordW+1)'(DISPLAY_WIDTH);
	localparam logic [CoordW:0]   HeightC = (CoordW+1)'(DISPLAY_HEIGHT);
	localparam logic [CoordW-1:0] WidthM  = CoordW'(DISPLAY_WIDTH);

	// palette registers
	color_t   pal_q [PalCount];
	reg_idx_t wr_idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_idx = reg_idx_t'(paddr[ApbAddrW-1:2]);
	assign wr_en  = psel && penable && pwrite && (paddr[ApbAddrW-1:2] < IdxW'(PalCount));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PalCount; i++) pal_q[i] <= PalReset[i];
		end else if (wr_en) begin
			pal_q[wr_idx] <= pwdata[ColorW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ApbAddrW-1:2] < IdxW'(PalCount))
			prdata = ApbDataW'(pal_q[paddr[ApbAddrW-1:2]]);
	end

	// stage enables, each stage fills when it is empty or the next one moves
	logic v1_q, v2_q, v3_q;
	logic en1, en2, en3;

	assign en3 = !v3_q || m_axis_tready;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign s_axis_tready = en1;
	assign m_axis_tvalid = v3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) v1_q <= s_axis_tvalid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
		end
	end

	// stage 1: input register
	logic [CoordW-1:0] x_s1, y_s1;
	logic [PixW-1:0]   pix_s1;

	always_ff @(posedge clk) begin
		if (en1 && s_axis_tvalid) begin
			x_s1   <= s_axis_tdata[CoordW-1:0];
			y_s1   <= s_axis_tdata[2*CoordW-1:CoordW];
			pix_s1 <= s_axis_tdata[2*CoordW+PixW-1:2*CoordW];
		end
	end

	// stage 1 to 2: widen channels, squared differences, linear position
	rgb_t            px;
	sq_t             sq_c [PalCount];
	logic            on_c;
	logic [PosW-1:0] pos_c;

	always_comb begin
		px.r  = {pix_s1[15:11], 3'b000};
		px.g  = {pix_s1[10:5], 2'b00};
		px.b  = {pix_s1[4:0], 3'b000};
		on_c  = ({1'b0, x_s1} < WidthC) && ({1'b0, y_s1} < HeightC);
		pos_c = PosW'(y_s1) * PosW'(WidthM) + PosW'(x_s1);
		for (int i = 0; i < PalCount; i++) begin
			sq_c[i].r = sq_diff(px.r, pal_q[i][23:16]);
			sq_c[i].g = sq_diff(px.g, pal_q[i][15:8]);
			sq_c[i].b = sq_diff(px.b, pal_q[i][7:0]);
		end
	end

	sq_t             sq_s2 [PalCount];
	logic            on_s2;
	logic [PosW-1:0] pos_s2;

	always_ff @(posedge clk) begin
		if (en2 && v1_q) begin
			sq_s2  <= sq_c;
			on_s2  <= on_c;
			pos_s2 <= pos_c;
		end
	end

	// stage 2 to 3: weighted sums and a min tree, left side holds lower indices
	dist_t d_c [PalCount];
	dist_t m01, m23, m45, m03, m46, mall;
	idx_t  i01, i23, i45, i03, i46, iall;

	always_comb begin
		for (int i = 0; i < PalCount; i++)
			d_c[i] = {2'b00, sq_s2[i].r, 1'b0} + {1'b0, sq_s2[i].g, 2'b00}
				+ DistW'(sq_s2[i].b);
		// ties keep the left, lower index
		{m01, i01} = (d_c[1] < d_c[0]) ? {d_c[1], 3'd1} : {d_c[0], 3'd0};
		{m23, i23} = (d_c[3] < d_c[2]) ? {d_c[3], 3'd3} : {d_c[2], 3'd2};
		{m45, i45} = (d_c[5] < d_c[4]) ? {d_c[5], 3'd5} : {d_c[4], 3'd4};
		{m03, i03} = (m23 < m01) ? {m23, i23} : {m01, i01};
		{m46, i46} = (d_c[6] < m45) ? {d_c[6], 3'd6} : {m45, i45};
		{mall, iall} = (m46 < m03) ? {m46, i46} : {m03, i03};
	end

	logic             we_s3;
	logic [AddrW-1:0] addr_s3;
	logic             hi_s3;
	idx_t             idx_s3;

	always_ff @(posedge clk) begin
		if (en3 && v2_q) begin
			we_s3   <= on_s2;
			addr_s3 <= on_s2 ? pos_s2[AddrW:1] : '0;
			hi_s3   <= on_s2 && !pos_s2[0];
			idx_s3  <= on_s2 ? iall : '0;
		end
	end

	assign m_axis_tdata = {1'b0, idx_s3, hi_s3, addr_s3, we_s3};

	// off-display results carry all-zero fields
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[22:1] == '0))
		else $error("off-display result has nonzero fields");

	// no palette index beyond the last entry
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[22:20] != 3'd7))
		else $error("color index out of range");

	// input only stalls when the whole pipeline is full and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v1_q && v2_q && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

	// an accepted pixel reaches stage one
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v1_q)
		else $error("accepted pixel lost");

endmodule
